### hw/rtl/sbmq_pkg.sv
// Package for the shared-buffer multi-queue core: field widths, word widths,
// operation and status codes. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package sbmq_pkg;

   // field widths of the request and response words
   localparam int OP_W     = 1;
   localparam int QUEUE_W  = 3;
   localparam int VALUE_W  = 32;
   localparam int STATUS_W = 2;

   localparam int REQ_TDATA_W = 40;
   localparam int RSP_TDATA_W = 40;

   // operation codes
   localparam logic [OP_W-1:0] OP_ENQ = 1'b0;
   localparam logic [OP_W-1:0] OP_DEQ = 1'b1;

   // status codes
   localparam logic [STATUS_W-1:0] ST_DONE  = 2'd0;
   localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
   localparam logic [STATUS_W-1:0] ST_EMPTY = 2'd2;

endpackage

`default_nettype wire

### hw/rtl/shared_buffer_multi_queue_core.sv
// Shared-buffer multi-queue core: several FIFO queues linked through one
// slot store with a free list. Depends on sbmq_pkg.
`timescale 1ns / 1ps
`default_nettype none

// Channel   Dir  Handshake              Word contents (lowest bit first)
// req       in   req_tvalid/req_tready  op[0], queue[3:1], value[35:4]
// rsp       out  rsp_tvalid/rsp_tready  value_out[31:0], status[33:32],
//                                       queue_now_empty[34], store_full[35]
//
// Steps: every word passes S_READ and S_ADDR; an enqueue into an empty queue, a
// dropped enqueue and a dequeue from an empty queue then go to S_DONE, an enqueue
// behind existing entries goes through S_LINK and a dequeue of a held entry through
// S_DEQ first. S_DONE loads the response register, and the next word is accepted in
// the cycle after the response loads. The sequence comes from the registered pointer
// stores: every pointer hop is a registered read followed by a write.
// Reset: synchronous, clears the sequencer, free-list head, fill count,
// queue occupancy bits and the response valid; memories are not cleared.
// Stalls: a held response blocks only the final step of the next word.

module shared_buffer_multi_queue_core
   import sbmq_pkg::*;
#(
   parameter int SLOTS  = 64,
   parameter int QUEUES = 8
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_tvalid,
   output      logic                   req_tready,
   // op[0], queue[3:1], value[35:4], zero fill
   input  wire logic [REQ_TDATA_W-1:0] req_tdata,
   output      logic                   rsp_tvalid,
   input  wire logic                   rsp_tready,
   // value_out[31:0], status[33:32], queue_now_empty[34], store_full[35], zero fill
   output      logic [RSP_TDATA_W-1:0] rsp_tdata
);

   // link width holds every slot number plus the null link (SLOTS)
   localparam int LW = $clog2(SLOTS + 1);
   localparam int AW = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int QW = (QUEUES > 1) ? $clog2(QUEUES) : 1;
   localparam logic [LW-1:0] NULL_LINK = LW'(SLOTS);

   localparam logic [2:0] S_IDLE = 3'd0;
   localparam logic [2:0] S_READ = 3'd1;
   localparam logic [2:0] S_ADDR = 3'd2;
   localparam logic [2:0] S_LINK = 3'd3;
   localparam logic [2:0] S_DEQ  = 3'd4;
   localparam logic [2:0] S_DONE = 3'd5;

   // stores: data and links per slot, head and tail per queue
   logic [VALUE_W-1:0] data_mem [SLOTS];
   logic [LW-1:0]      link_mem [SLOTS];
   logic [LW-1:0]      head_mem [QUEUES];
   logic [LW-1:0]      tail_mem [QUEUES];

   logic [2:0]          state_ff, state_in;
   logic [OP_W-1:0]     op_ff, op_in;
   logic [QUEUE_W-1:0]  q_ff, q_in;
   logic [VALUE_W-1:0]  val_ff, val_in;
   logic [LW-1:0]       free_head_ff, free_head_in;
   // slots at or above the fill count were never taken; their link is taken as i+1
   logic [LW-1:0]       fill_ff, fill_in;
   logic [QUEUES-1:0]   nonempty_ff, nonempty_in;
   logic [LW-1:0]       slot_ff, slot_in;
   logic [STATUS_W-1:0] status_ff, status_in;
   logic [VALUE_W-1:0]  result_ff, result_in;
   logic                rsp_valid_ff, rsp_valid_in;
   logic [RSP_TDATA_W-1:0] rsp_data_ff, rsp_data_in;

   // registered read data
   logic [VALUE_W-1:0] data_rd_ff;
   logic [LW-1:0]      link_rd_ff;
   logic [LW-1:0]      head_rd_ff;
   logic [LW-1:0]      tail_rd_ff;

   // memory control
   logic              link_we;
   logic [AW-1:0]     link_waddr;
   logic [LW-1:0]     link_wdata;
   logic [AW-1:0]     link_raddr;
   logic              data_we;
   logic              head_we;
   logic [LW-1:0]     head_wdata;
   logic              tail_we;
   logic              qrd_en;

   logic              accept;
   logic              rsp_load;
   logic [QW-1:0]     q_idx;
   logic              q_ok;
   logic              now_empty;
   logic              store_full;

   assign req_tready = (state_ff == S_IDLE);
   assign accept     = req_tvalid && req_tready;
   assign q_idx      = QW'(q_ff);
   assign q_ok       = (32'(q_ff) < QUEUES);
   assign now_empty  = q_ok ? !nonempty_ff[q_idx] : 1'b1;
   assign store_full = (free_head_ff == NULL_LINK);

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = rsp_data_ff;

   // sequencer: one pointer step per cycle, holding in S_DONE while a response waits
   always_comb begin
      state_in     = state_ff;
      op_in        = op_ff;
      q_in         = q_ff;
      val_in       = val_ff;
      free_head_in = free_head_ff;
      fill_in      = fill_ff;
      nonempty_in  = nonempty_ff;
      slot_in      = slot_ff;
      status_in    = status_ff;
      result_in    = result_ff;
      link_we      = 1'b0;
      link_waddr   = free_head_ff[AW-1:0];
      link_wdata   = NULL_LINK;
      link_raddr   = free_head_ff[AW-1:0];
      data_we      = 1'b0;
      head_we      = 1'b0;
      head_wdata   = free_head_ff;
      tail_we      = 1'b0;
      qrd_en       = 1'b0;
      rsp_load     = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               op_in    = req_tdata[0];
               q_in     = req_tdata[3:1];
               val_in   = req_tdata[35:4];
               state_in = S_READ;
            end
         end
         S_READ: begin
            // fetch queue pointers and the link of the free-list head
            qrd_en   = 1'b1;
            state_in = S_ADDR;
         end
         S_ADDR: begin
            result_in = '0;
            status_in = ST_DONE;
            state_in  = S_DONE;
            if (!q_ok) begin
               status_in = (op_ff == OP_ENQ) ? ST_FULL : ST_EMPTY;
            end else if (op_ff == OP_ENQ) begin
               if (store_full) begin
                  status_in = ST_FULL;
               end else begin
                  // pop the free list, append slot to the queue
                  free_head_in = (free_head_ff >= fill_ff) ? free_head_ff + LW'(1)
                                                           : link_rd_ff;
                  if (free_head_ff == fill_ff) begin
                     fill_in = fill_ff + LW'(1);
                  end
                  data_we     = 1'b1;
                  link_we     = 1'b1;
                  link_waddr  = free_head_ff[AW-1:0];
                  link_wdata  = NULL_LINK;
                  head_we     = !nonempty_ff[q_idx];
                  head_wdata  = free_head_ff;
                  tail_we     = 1'b1;
                  nonempty_in[q_idx] = 1'b1;
                  slot_in     = free_head_ff;
                  if (nonempty_ff[q_idx]) begin
                     state_in = S_LINK;
                  end
               end
            end else begin
               if (!nonempty_ff[q_idx]) begin
                  status_in = ST_EMPTY;
               end else begin
                  // fetch the successor of the head slot
                  link_raddr = head_rd_ff[AW-1:0];
                  state_in   = S_DEQ;
               end
            end
         end
         S_LINK: begin
            // hook the new slot behind the old tail
            link_we    = 1'b1;
            link_waddr = tail_rd_ff[AW-1:0];
            link_wdata = slot_ff;
            state_in   = S_DONE;
         end
         S_DEQ: begin
            // unlink the head slot and push it on the free list
            head_we    = 1'b1;
            head_wdata = link_rd_ff;
            if (link_rd_ff == NULL_LINK) begin
               nonempty_in[q_idx] = 1'b0;
            end
            link_we      = 1'b1;
            link_waddr   = head_rd_ff[AW-1:0];
            link_wdata   = free_head_ff;
            free_head_in = head_rd_ff;
            result_in    = data_rd_ff;
            state_in     = S_DONE;
         end
         S_DONE: begin
            // hold until the response register is free
            if (!rsp_valid_ff || rsp_tready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      rsp_data_in  = rsp_data_ff;
      if (rsp_load) begin
         rsp_valid_in = 1'b1;
         rsp_data_in  = {4'b0000, store_full, now_empty, status_ff, result_ff};
      end else if (rsp_tready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         free_head_ff <= '0;
         fill_ff      <= '0;
         nonempty_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         free_head_ff <= free_head_in;
         fill_ff      <= fill_in;
         nonempty_ff  <= nonempty_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff       <= op_in;
      q_ff        <= q_in;
      val_ff      <= val_in;
      slot_ff     <= slot_in;
      status_ff   <= status_in;
      result_ff   <= result_in;
      rsp_data_ff <= rsp_data_in;
   end

   // slot stores
   always_ff @(posedge clock) begin
      if (data_we) begin
         data_mem[free_head_ff[AW-1:0]] <= val_ff;
      end
      data_rd_ff <= data_mem[head_rd_ff[AW-1:0]];
   end

   always_ff @(posedge clock) begin
      if (link_we) begin
         link_mem[link_waddr] <= link_wdata;
      end
      link_rd_ff <= link_mem[link_raddr];
   end

   // queue pointer stores
   always_ff @(posedge clock) begin
      if (head_we) begin
         head_mem[q_idx] <= head_wdata;
      end
      if (qrd_en) begin
         head_rd_ff <= head_mem[q_idx];
      end
   end

   always_ff @(posedge clock) begin
      if (tail_we) begin
         tail_mem[q_idx] <= free_head_ff;
      end
      if (qrd_en) begin
         tail_rd_ff <= tail_mem[q_idx];
      end
   end

endmodule

`default_nettype wire

### tb/shared_buffer_multi_queue_checker.sv
// Checker for the shared-buffer multi-queue core: watches the req and rsp
// streams, keeps its own copy of the queues and compares every response word.
// Depends on sbmq_pkg.
`timescale 1ns / 1ps

module shared_buffer_multi_queue_checker
   import sbmq_pkg::*;
#(
   parameter int SLOTS  = 64,
   parameter int QUEUES = 8
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_tvalid,
   input  logic                   req_tready,
   // op[0], queue[3:1], value[35:4], zero fill
   input  logic [REQ_TDATA_W-1:0] req_tdata,
   input  logic                   rsp_tvalid,
   input  logic                   rsp_tready,
   // value_out[31:0], status[33:32], queue_now_empty[34], store_full[35], zero fill
   input  logic [RSP_TDATA_W-1:0] rsp_tdata,
   output int                     fail_count,
   output int                     replies_pending
);

   localparam int LINK_W = $clog2(SLOTS + 1);
   localparam logic [LINK_W-1:0] NIL = LINK_W'(SLOTS);

   // one response word, packed in the order of rsp_tdata[35:0]
   typedef struct packed {
      logic                store_full;
      logic                now_empty;
      logic [STATUS_W-1:0] status;
      logic [VALUE_W-1:0]  value_out;
   } reply_type;

   logic [VALUE_W-1:0] slot_data  [SLOTS];
   logic [LINK_W-1:0]  slot_link  [SLOTS];
   logic [LINK_W-1:0]  queue_head [QUEUES];
   logic [LINK_W-1:0]  queue_tail [QUEUES];
   logic [LINK_W-1:0]  free_head;

   reply_type replies [$];

   initial begin
      fail_count      = 0;
      replies_pending = 0;
   end

   function automatic void clear_store();
      for (int i = 0; i < SLOTS; i++) slot_link[i] = LINK_W'(i + 1);
      for (int i = 0; i < QUEUES; i++) begin
         queue_head[i] = NIL;
         queue_tail[i] = NIL;
      end
      free_head = '0;
   endfunction

   // Apply one operation to the shadow store and return the response it gives.
   function automatic reply_type step_store(input logic [OP_W-1:0] op,
                                            input logic [QUEUE_W-1:0] q,
                                            input logic [VALUE_W-1:0] v);
      reply_type r;
      logic [LINK_W-1:0] s;
      r.value_out  = '0;
      r.status     = ST_DONE;
      r.now_empty  = 1'b1;
      r.store_full = 1'b0;
      if (int'(q) >= QUEUES) begin
         // nonexistent queue: always empty, accepts nothing
         r.status = (op == OP_ENQ) ? ST_FULL : ST_EMPTY;
      end else if (op == OP_ENQ) begin
         if (free_head == NIL) begin
            r.status = ST_FULL;
         end else begin
            s = free_head;
            free_head = slot_link[s];
            if (queue_head[q] == NIL) queue_head[q] = s;
            else slot_link[queue_tail[q]] = s;
            slot_link[s]  = NIL;
            queue_tail[q] = s;
            slot_data[s]  = v;
         end
      end else begin
         if (queue_head[q] == NIL) begin
            r.status = ST_EMPTY;
         end else begin
            s = queue_head[q];
            queue_head[q] = slot_link[s];
            if (queue_head[q] == NIL) queue_tail[q] = NIL;
            slot_link[s] = free_head;
            free_head    = s;
            r.value_out  = slot_data[s];
         end
      end
      if (int'(q) < QUEUES) r.now_empty = (queue_head[q] == NIL);
      r.store_full = (free_head == NIL);
      return r;
   endfunction

   always @(posedge clock) begin : watch
      reply_type got;
      reply_type want;
      if (reset) begin
         clear_store();
         replies.delete();
      end else begin
         if (req_tvalid && req_tready)
            replies.push_back(step_store(req_tdata[0], req_tdata[3:1], req_tdata[35:4]));
         if (rsp_tvalid && rsp_tready) begin
            got = reply_type'(rsp_tdata[35:0]);
            if (replies.size() == 0) begin
               if (fail_count < 10)
                  $display("%0t: response word with none expected: value_out=%h status=%0d",
                           $realtime, got.value_out, got.status);
               fail_count++;
            end else begin
               want = replies.pop_front();
               if (got.value_out !== want.value_out || got.status !== want.status ||
                   got.now_empty !== want.now_empty || got.store_full !== want.store_full) begin
                  if (fail_count < 10) begin
                     $write("%0t: mismatch: expected value_out=%h status=%0d empty=%b full=%b, ",
                            $realtime, want.value_out, want.status, want.now_empty,
                            want.store_full);
                     $display("got value_out=%h status=%0d empty=%b full=%b",
                              got.value_out, got.status, got.now_empty, got.store_full);
                  end
                  fail_count++;
               end
            end
         end
      end
      replies_pending = replies.size();
   end

endmodule

### tb/shared_buffer_multi_queue_core_tb.sv
// Testbench top for the shared-buffer multi-queue core: drives request words,
// stalls the response side and reports the verdict. Depends on sbmq_pkg,
// shared_buffer_multi_queue_core and shared_buffer_multi_queue_checker.
`timescale 1ns / 1ps

module shared_buffer_multi_queue_core_tb;
   import sbmq_pkg::*;

   localparam int RANDOM_WORDS = 1630;
   localparam int CYCLE_LIMIT  = 400000;

   logic                   clock;
   logic                   reset;
   logic                   req_tvalid;
   logic                   req_tready;
   logic [REQ_TDATA_W-1:0] req_tdata;
   logic                   rsp_tvalid;
   logic                   rsp_tready;
   logic [RSP_TDATA_W-1:0] rsp_tdata;

   int fail_count;
   int replies_pending;
   int hold_off_cycles;   // set once by the stimulus, counted down by the receiver
   int cycle_count;

   shared_buffer_multi_queue_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   shared_buffer_multi_queue_checker checker_i (
      .clock           (clock),
      .reset           (reset),
      .req_tvalid      (req_tvalid),
      .req_tready      (req_tready),
      .req_tdata       (req_tdata),
      .rsp_tvalid      (rsp_tvalid),
      .rsp_tready      (rsp_tready),
      .rsp_tdata       (rsp_tdata),
      .fail_count      (fail_count),
      .replies_pending (replies_pending)
   );

   initial clock = 1'b0;
   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // Watchdog: end the run if the block hangs.
   initial cycle_count = 0;
   always @(posedge clock) begin
      cycle_count++;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("[FAIL] regression broken");
         $finish;
      end
   end

   // Receiver: rotate a stall pattern that is redrawn whenever its random run length runs out;
   // an all-ones pattern gives stretches without any stall.
   initial begin : receiver
      logic [7:0] stall_pattern;
      int         pattern_left;
      rsp_tready    = 1'b0;
      stall_pattern = 8'hFF;
      pattern_left  = 0;
      forever begin
         @(negedge clock);
         if (hold_off_cycles > 0) begin
            // long hold-off: let the block back up into its input
            rsp_tready = 1'b0;
            hold_off_cycles--;
         end else begin
            if (pattern_left == 0) begin
               case ($urandom_range(0, 3))
                  0:       stall_pattern = 8'hFF;
                  1:       stall_pattern = 8'($urandom);
                  2:       stall_pattern = 8'h11;
                  default: stall_pattern = 8'($urandom | $urandom);
               endcase
               pattern_left = $urandom_range(16, 96);
            end
            rsp_tready    = stall_pattern[0];
            stall_pattern = {stall_pattern[0], stall_pattern[7:1]};
            pattern_left--;
         end
      end
   end

   // Offer one word and hold it until the block takes it.
   task automatic send_word(input logic [OP_W-1:0] op, input logic [QUEUE_W-1:0] q,
                            input logic [VALUE_W-1:0] v);
      @(negedge clock);
      req_tvalid = 1'b1;
      req_tdata  = {4'b0, v, q, op};
      do @(posedge clock); while (!req_tready);
   endtask

   // Drop valid for a gap of the given number of cycles.
   task automatic idle_for(input int cycles);
      @(negedge clock);
      req_tvalid = 1'b0;
      repeat (cycles - 1) @(negedge clock);
   endtask

   // Stop sending until every outstanding response has come back.
   task automatic drain_replies();
      idle_for(1);
      while (replies_pending != 0) @(negedge clock);
   endtask

   // Mostly random data, with the extremes of the signed range now and then.
   function automatic logic [VALUE_W-1:0] pick_value();
      case ($urandom_range(0, 7))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2:       return 32'h0000_0000;
         3:       return 32'hFFFF_FFFF;
         default: return $urandom;
      endcase
   endfunction

   initial begin : stimulus
      int                 burst_left;
      int                 phase_left;
      int                 enq_percent;
      logic               focused;
      logic [QUEUE_W-1:0] focus_a;
      logic [QUEUE_W-1:0] focus_b;
      logic [OP_W-1:0]    op;
      logic [QUEUE_W-1:0] q;
      hold_off_cycles = 0;
      req_tvalid      = 1'b0;
      req_tdata       = '0;
      reset           = 1'b1;
      burst_left      = 0;
      phase_left      = 0;
      enq_percent     = 50;
      focused         = 1'b0;
      focus_a         = '0;
      focus_b         = '0;
      repeat (3) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      // Directed: dequeue from empty queues, extremes of data and queue number,
      // FIFO order within one queue, and a queue emptied by its last dequeue.
      send_word(OP_DEQ, 3'd0, 32'hFFFF_FFFF);
      send_word(OP_DEQ, 3'd7, 32'h0000_0000);
      send_word(OP_ENQ, 3'd0, 32'h7FFF_FFFF);
      send_word(OP_ENQ, 3'd7, 32'h8000_0000);
      send_word(OP_ENQ, 3'd0, 32'hFFFF_FFFF);
      idle_for(3);
      send_word(OP_ENQ, 3'd3, 32'h0000_0000);
      send_word(OP_ENQ, 3'd5, 32'h0000_0001);
      send_word(OP_ENQ, 3'd0, 32'h5A5A_A5A5);
      send_word(OP_DEQ, 3'd0, 32'h0000_0000);
      send_word(OP_DEQ, 3'd0, 32'h0000_0000);
      send_word(OP_ENQ, 3'd0, 32'hA5A5_5A5A);
      send_word(OP_DEQ, 3'd0, 32'h0000_0000);
      send_word(OP_DEQ, 3'd0, 32'h0000_0000);
      send_word(OP_DEQ, 3'd0, 32'h0000_0000);
      idle_for(5);
      send_word(OP_DEQ, 3'd7, 32'h0000_0000);
      send_word(OP_DEQ, 3'd3, 32'h0000_0000);
      send_word(OP_DEQ, 3'd5, 32'hFFFF_FFFF);
      send_word(OP_DEQ, 3'd5, 32'h0000_0000);
      send_word(OP_ENQ, 3'd1, 32'h1234_5678);
      send_word(OP_ENQ, 3'd2, 32'h8765_4321);
      drain_replies();

      // Random: phases that lean toward filling, draining or neither, some of
      // them aimed at two queues so single queues grow long and run dry.
      for (int i = 0; i < RANDOM_WORDS; i++) begin
         if (phase_left == 0) begin
            case ($urandom_range(0, 2))
               0:       enq_percent = 85;
               1:       enq_percent = 15;
               default: enq_percent = 50;
            endcase
            focused    = 1'($urandom_range(0, 1));
            focus_a    = QUEUE_W'($urandom);
            focus_b    = QUEUE_W'($urandom);
            phase_left = $urandom_range(30, 120);
         end
         if (i == 500) hold_off_cycles = 300;
         if (i == 900 || i == 1300) drain_replies();
         op = ($urandom_range(1, 100) <= enq_percent) ? OP_ENQ : OP_DEQ;
         if (focused) q = $urandom_range(0, 1) ? focus_a : focus_b;
         else q = QUEUE_W'($urandom_range(0, 7));
         send_word(op, q, pick_value());
         phase_left--;
         if (burst_left == 0) begin
            idle_for($urandom_range(1, 10));
            burst_left = $urandom_range(1, 40);
         end else begin
            burst_left--;
         end
      end

      // Wind down: wait for the last responses, then watch for strays.
      idle_for(1);
      while (replies_pending != 0) @(negedge clock);
      repeat (20) @(negedge clock);
      if (fail_count == 0 && replies_pending == 0) begin
         $display("[ OK ] regression clean");
      end else begin
         $display("[FAIL] regression broken");
      end
      $finish;
   end

endmodule
